// File: rtl/mbrtu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mbrtu_pkg;

   // Largest byte count field a frame may carry
   localparam logic [7:0] MAX_DATA_BYTES = 8'd240;

   // Result status codes
   localparam logic [2:0] ST_BUSY = 3'd0;
   localparam logic [2:0] ST_OK   = 3'd1;
   localparam logic [2:0] ST_CRC  = 3'd2;
   localparam logic [2:0] ST_SIZE = 3'd3;
   localparam logic [2:0] ST_FUNC = 3'd4;
   localparam logic [2:0] ST_ADDR = 3'd5;

   // Register indexes
   localparam logic [1:0] CSR_ROLE      = 2'd0;
   localparam logic [1:0] CSR_OWN_ADDR  = 2'd1;
   localparam logic [1:0] CSR_BROADCAST = 2'd2;
   localparam logic [1:0] CSR_EXC_STAT  = 2'd3;

   // Roles
   localparam logic ROLE_MASTER = 1'b0;
   localparam logic ROLE_SLAVE  = 1'b1;

   // Function codes
   localparam logic [7:0] FC_EXC_MASK   = 8'h80;
   localparam logic [7:0] FC_READ_COILS = 8'h01;
   localparam logic [7:0] FC_READ_INREG = 8'h04;
   localparam logic [7:0] FC_WRITE_COIL = 8'h05;
   localparam logic [7:0] FC_WRITE_REG  = 8'h06;
   localparam logic [7:0] FC_EXC_STATUS = 8'h07;
   localparam logic [7:0] FC_WRITE_MCOIL = 8'h0F;
   localparam logic [7:0] FC_WRITE_MREG = 8'h10;
   localparam logic [7:0] FC_RW_MREG    = 8'h17;
   localparam logic [7:0] FC_ENCAP      = 8'h2B;

   // Frame lengths and byte count positions
   localparam logic [7:0] LEN_EXCEPTION = 8'd5;
   localparam logic [7:0] LEN_FIXED     = 8'd8;
   localparam logic [7:0] LEN_ENCAP     = 8'd7;
   localparam logic [7:0] LEN_EXC_STAT  = 8'd4;
   localparam logic [7:0] LEN_OVERHEAD  = 8'd4;
   localparam logic [7:0] POS_WRITE     = 8'd6;
   localparam logic [7:0] POS_RW        = 8'd10;
   localparam logic [7:0] POS_READ_RSP  = 8'd2;

   // CRC-16, reflected
   localparam logic [15:0] CRC_PRESET = 16'hFFFF;
   localparam logic [15:0] CRC_POLY   = 16'hA001;

   // Result word fields
   typedef struct packed {
      logic [7:0] payload_length;
      logic [7:0] byte_index;
      logic [7:0] data_byte;
      logic       frame_end;
      logic       is_payload;
      logic [2:0] status;
   } rsp_type;

   // Fold one byte into the CRC, one bit per step
   function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// File: rtl/modbus_rtu_frame_receiver_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// A word loads into the input register when accepted; the result register and
// the frame state load from it together when the decode stage advances.
// Throughput: one word per cycle unless rsp_tready stalls the result register;
// the CRC update and frame decode fit one stage.
// Reset (synchronous, active high) clears both stages and the frame state and
// loads register defaults: slave role, address 1, no broadcast, no function 0x07.
module modbus_rtu_frame_receiver_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   // Received bytes
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  wire logic        req_tuser,   // [0] action (1 = frame gap)
   // Results
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,   // [7:0] data_byte, [15:8] byte_index,
                                         // [23:16] payload_length
   output logic [3:0]       rsp_tuser,   // [2:0] status, [3] is_payload
   output logic             rsp_tlast,   // frame_end
   // Configuration
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [7:0]  csr_wdata
);
   import mbrtu_pkg::*;

   logic        role_ff, bcast_ff, exc_stat_ff;
   logic [7:0]  own_addr_ff;

   logic        in_valid_ff, in_gap_ff;
   logic [7:0]  in_byte_ff;

   logic        out_valid_ff;
   rsp_type     out_ff, out_in;

   logic [7:0]  byte_count_ff, byte_count_in;
   logic [7:0]  func_ff, func_in;
   logic [7:0]  exp_len_ff, exp_len_in;
   logic [15:0] crc_ff, crc_in;

   logic        adv, process;

   // Advance when the result register is free or being drained
   assign adv        = !out_valid_ff || rsp_tready;
   assign process    = in_valid_ff && adv;
   assign req_tready = !in_valid_ff || adv;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_ff.payload_length, out_ff.byte_index, out_ff.data_byte};
   assign rsp_tuser  = {out_ff.is_payload, out_ff.status};
   assign rsp_tlast  = out_ff.frame_end;

   // Decode one byte against the frame state
   always_comb begin
      logic [7:0]  b, idx, f, flen, pos, cnt;
      logic [15:0] crc_new;
      logic [2:0]  st;
      logic        acc, pay, fin;

      b       = in_byte_ff;
      idx     = byte_count_ff;
      f       = func_ff;
      flen    = 8'd0;
      pos     = POS_WRITE;
      st      = ST_BUSY;
      acc     = 1'b0;
      pay     = 1'b0;
      fin     = 1'b0;
      cnt     = idx + 8'd1;
      crc_new = crc16_byte(crc_ff, b);

      byte_count_in = byte_count_ff;
      func_in       = func_ff;
      exp_len_in    = exp_len_ff;
      crc_in        = crc_ff;
      out_in        = '0;

      if (in_gap_ff) begin
         byte_count_in = 8'd0;
         func_in       = 8'd0;
         exp_len_in    = 8'd0;
         crc_in        = CRC_PRESET;
      end else begin
         if (idx == 8'd0) begin
            if (role_ff == ROLE_SLAVE &&
                !(b == own_addr_ff || (bcast_ff && b == 8'd0))) begin
               st = ST_ADDR;
            end else begin
               acc = 1'b1;
            end
         end else if (idx == 8'd1) begin
            func_in = b;
            acc     = 1'b1;
         end else if (role_ff == ROLE_MASTER) begin
            if ((f & FC_EXC_MASK) != 8'd0) begin
               acc  = 1'b1;
               flen = LEN_EXCEPTION;
            end else if (f >= FC_READ_COILS && f <= FC_READ_INREG) begin
               if (idx == POS_READ_RSP) begin
                  if (b > MAX_DATA_BYTES) begin
                     st = ST_SIZE;
                  end else begin
                     acc        = 1'b1;
                     exp_len_in = b + LEN_EXCEPTION;
                     flen       = exp_len_in;
                  end
               end else if (exp_len_ff > idx) begin
                  acc  = 1'b1;
                  flen = exp_len_ff;
               end
            end else if (f inside {FC_WRITE_COIL, FC_WRITE_REG, FC_WRITE_MCOIL,
                                   FC_WRITE_MREG}) begin
               acc  = 1'b1;
               flen = LEN_FIXED;
            end else begin
               st = ST_FUNC;
            end
         end else begin
            if (f inside {FC_WRITE_MCOIL, FC_WRITE_MREG, FC_RW_MREG}) begin
               pos = (f == FC_RW_MREG) ? POS_RW : POS_WRITE;
               if (idx < pos) begin
                  acc = 1'b1;
               end else if (idx == pos) begin
                  if (b > MAX_DATA_BYTES) begin
                     st = ST_SIZE;
                  end else begin
                     acc        = 1'b1;
                     exp_len_in = b + pos + 8'd3;
                     flen       = exp_len_in;
                  end
               end else if (exp_len_ff > idx) begin
                  acc  = 1'b1;
                  flen = exp_len_ff;
               end
            end else if ((f >= FC_READ_COILS && f <= FC_WRITE_REG) || f == FC_ENCAP) begin
               acc  = 1'b1;
               flen = (f == FC_ENCAP) ? LEN_ENCAP : LEN_FIXED;
            end else if (f == FC_EXC_STATUS && exc_stat_ff) begin
               acc  = 1'b1;
               flen = LEN_EXC_STAT;
            end else begin
               st = ST_FUNC;
            end
         end

         out_in.data_byte  = b;
         out_in.byte_index = idx;

         if (st == ST_SIZE || st == ST_FUNC) begin
            fin           = 1'b1;
            byte_count_in = 8'd0;
            func_in       = 8'd0;
            exp_len_in    = 8'd0;
            crc_in        = CRC_PRESET;
         end else if (st == ST_ADDR) begin
            fin = 1'b1;
         end else if (acc) begin
            pay = (idx >= 8'd2) &&
                  (flen == 8'd0 || ({1'b0, idx} + 9'd2) < {1'b0, flen});
            crc_in        = crc_new;
            byte_count_in = cnt;
            if (flen != 8'd0 && cnt >= flen) begin
               fin = 1'b1;
               st  = (crc_new == 16'd0) ? ST_OK : ST_CRC;
               if (crc_new == 16'd0) begin
                  out_in.payload_length = cnt - LEN_OVERHEAD;
               end
               byte_count_in = 8'd0;
               func_in       = 8'd0;
               exp_len_in    = 8'd0;
               crc_in        = CRC_PRESET;
            end
         end

         out_in.status     = st;
         out_in.is_payload = pay;
         out_in.frame_end  = fin;
      end
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         role_ff     <= ROLE_SLAVE;
         own_addr_ff <= 8'd1;
         bcast_ff    <= 1'b0;
         exc_stat_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ROLE:      role_ff     <= csr_wdata[0];
            CSR_OWN_ADDR:  own_addr_ff <= csr_wdata;
            CSR_BROADCAST: bcast_ff    <= csr_wdata[0];
            CSR_EXC_STAT:  exc_stat_ff <= csr_wdata[0];
            default:       ;
         endcase
      end
   end

   // Input register: hold the word until the decode stage takes it
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
         in_gap_ff  <= req_tuser;
      end
   end

   // Frame state: advance on each decoded word
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff <= 8'd0;
         func_ff       <= 8'd0;
         exp_len_ff    <= 8'd0;
         crc_ff        <= CRC_PRESET;
      end else if (process) begin
         byte_count_ff <= byte_count_in;
         func_ff       <= func_in;
         exp_len_ff    <= exp_len_in;
         crc_ff        <= crc_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= in_valid_ff;
      end
      if (process) begin
         out_ff <= out_in;
      end
   end

endmodule

`default_nettype wire

// File: test/modbus_rtu_frame_receiver_unit_test.sv
`timescale 1ns / 1ps

module modbus_rtu_frame_receiver_unit_test;
   import mbrtu_pkg::*;

   localparam int STALL_LIMIT   = 2000;
   localparam int HOLD_CYCLES   = 300;
   localparam int PHASE_WORDS   = 40;
   localparam int N_PHASE       = 8;
   localparam int N_PROBE       = 24;
   // Count byte plus two CRC bytes after the byte count position
   localparam logic [7:0] TAIL_BYTES = 8'd3;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic [3:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = CSR_ROLE;
   logic [7:0]  csr_wdata = 8'h00;

   modbus_rtu_frame_receiver_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // Receiver settings as last written
   logic       cfg_role = ROLE_SLAVE;
   logic [7:0] cfg_own  = 8'd1;
   logic       cfg_bcast = 1'b0;
   logic       cfg_exc  = 1'b0;

   // Frame tracking state of the predictor
   logic [7:0]  trk_pos   = 8'd0;
   logic [7:0]  trk_fcode = 8'd0;
   logic [7:0]  trk_goal  = 8'd0;
   logic [15:0] trk_crc   = CRC_PRESET;

   rsp_type pending_frame_reports [$];
   int      fail_count = 0;
   int      sent_words = 0;
   int      quiet_cycles = 0;
   bit      send_idle_on = 1'b0;
   bit      rx_stall_on = 1'b0;
   bit      hold_off_req = 1'b0;
   bit      dirty = 1'b0;

   typedef struct {
      logic       gap;
      logic [7:0] rx;
      logic       typed;
      rsp_type    want;
   } probe_row_type;

   // Reset settings: slave at address 1, no broadcast, no exception status
   probe_row_type probe_tbl [N_PROBE] = '{
      '{1'b1, 8'h00, 1'b1, '{8'd0, 8'd0, 8'h00, 1'b0, 1'b0, ST_BUSY}},
      '{1'b0, 8'h00, 1'b1, '{8'd0, 8'd0, 8'h00, 1'b1, 1'b0, ST_ADDR}},
      '{1'b0, 8'hFF, 1'b1, '{8'd0, 8'd0, 8'hFF, 1'b1, 1'b0, ST_ADDR}},
      // read holding register request with a good CRC
      '{1'b0, 8'h01, 1'b0, '0},
      '{1'b0, 8'h03, 1'b0, '0},
      '{1'b0, 8'h00, 1'b0, '0},
      '{1'b0, 8'h00, 1'b0, '0},
      '{1'b0, 8'h00, 1'b0, '0},
      '{1'b0, 8'h01, 1'b0, '0},
      '{1'b0, 8'h84, 1'b0, '0},
      '{1'b0, 8'h0A, 1'b1, '{8'd4, 8'd7, 8'h0A, 1'b1, 1'b0, ST_OK}},
      // unknown function, caught on the third byte
      '{1'b0, 8'h01, 1'b0, '0},
      '{1'b0, 8'h63, 1'b0, '0},
      '{1'b0, 8'h55, 1'b1, '{8'd0, 8'd2, 8'h55, 1'b1, 1'b0, ST_FUNC}},
      // write multiple registers with a byte count one above the maximum
      '{1'b0, 8'h01, 1'b0, '0},
      '{1'b0, 8'h10, 1'b0, '0},
      '{1'b0, 8'h00, 1'b0, '0},
      '{1'b0, 8'h01, 1'b0, '0},
      '{1'b0, 8'h00, 1'b0, '0},
      '{1'b0, 8'h02, 1'b0, '0},
      '{1'b0, 8'hF1, 1'b1, '{8'd0, 8'd6, 8'hF1, 1'b1, 1'b0, ST_SIZE}},
      // frame gap in the middle of a frame
      '{1'b0, 8'h01, 1'b0, '0},
      '{1'b0, 8'h10, 1'b0, '0},
      '{1'b1, 8'h5A, 1'b1, '{8'd0, 8'd0, 8'h00, 1'b0, 1'b0, ST_BUSY}}
   };

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Reflected CRC-16, one data bit per step
   function automatic logic [15:0] crc_fold(input logic [15:0] acc, input logic [7:0] b);
      logic [15:0] c;
      c = acc;
      for (int k = 0; k < 8; k++) begin
         c = (c[0] ^ b[k]) ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   function automatic void clear_track();
      trk_pos   = 8'd0;
      trk_fcode = 8'd0;
      trk_goal  = 8'd0;
      trk_crc   = CRC_PRESET;
   endfunction

   // Work out the report for one received word and advance the frame state
   function automatic rsp_type predict_byte_report(input logic gap, input logic [7:0] b);
      rsp_type    r;
      logic [7:0] idx;
      logic [7:0] fc;
      logic [7:0] goal;
      logic [7:0] cpos;
      logic       take;
      r = '0;
      if (gap) begin
         clear_track();
         return r;
      end
      idx  = trk_pos;
      fc   = trk_fcode;
      goal = 8'd0;
      take = 1'b0;
      r.data_byte  = b;
      r.byte_index = idx;
      r.status     = ST_BUSY;

      if (idx == 8'd0) begin
         if (cfg_role == ROLE_SLAVE && !(b == cfg_own || (cfg_bcast && b == 8'h00)))
            r.status = ST_ADDR;
         else
            take = 1'b1;
      end else if (idx == 8'd1) begin
         trk_fcode = b;
         take = 1'b1;
      end else if (cfg_role == ROLE_MASTER) begin
         // responses
         if ((fc & FC_EXC_MASK) != 8'h00) begin
            take = 1'b1;
            goal = LEN_EXCEPTION;
         end else if (fc >= FC_READ_COILS && fc <= FC_READ_INREG) begin
            if (idx == POS_READ_RSP) begin
               if (b > MAX_DATA_BYTES) begin
                  r.status = ST_SIZE;
               end else begin
                  take = 1'b1;
                  trk_goal = b + POS_READ_RSP + TAIL_BYTES;
                  goal = trk_goal;
               end
            end else if (trk_goal > idx) begin
               take = 1'b1;
               goal = trk_goal;
            end
         end else if (fc == FC_WRITE_COIL || fc == FC_WRITE_REG ||
                      fc == FC_WRITE_MCOIL || fc == FC_WRITE_MREG) begin
            take = 1'b1;
            goal = LEN_FIXED;
         end else begin
            r.status = ST_FUNC;
         end
      end else begin
         // requests
         if (fc == FC_WRITE_MCOIL || fc == FC_WRITE_MREG || fc == FC_RW_MREG) begin
            cpos = (fc == FC_RW_MREG) ? POS_RW : POS_WRITE;
            if (idx < cpos) begin
               take = 1'b1;
            end else if (idx == cpos) begin
               if (b > MAX_DATA_BYTES) begin
                  r.status = ST_SIZE;
               end else begin
                  take = 1'b1;
                  trk_goal = b + cpos + TAIL_BYTES;
                  goal = trk_goal;
               end
            end else if (trk_goal > idx) begin
               take = 1'b1;
               goal = trk_goal;
            end
         end else if ((fc >= FC_READ_COILS && fc <= FC_WRITE_REG) || fc == FC_ENCAP) begin
            take = 1'b1;
            goal = (fc == FC_ENCAP) ? LEN_ENCAP : LEN_FIXED;
         end else if (fc == FC_EXC_STATUS && cfg_exc) begin
            take = 1'b1;
            goal = LEN_EXC_STAT;
         end else begin
            r.status = ST_FUNC;
         end
      end

      if (r.status == ST_SIZE || r.status == ST_FUNC) begin
         r.frame_end = 1'b1;
         clear_track();
      end else if (r.status == ST_ADDR) begin
         r.frame_end = 1'b1;
      end else if (take) begin
         r.is_payload = (idx >= 8'd2) &&
                        (goal == 8'd0 || ({1'b0, idx} + 9'd2) < {1'b0, goal});
         trk_crc = crc_fold(trk_crc, b);
         trk_pos = idx + 8'd1;
         if (goal != 8'd0 && trk_pos >= goal) begin
            r.frame_end = 1'b1;
            r.status = (trk_crc == 16'h0000) ? ST_OK : ST_CRC;
            if (r.status == ST_OK)
               r.payload_length = trk_pos - LEN_OVERHEAD;
            clear_track();
         end
      end
      return r;
   endfunction

   // Offer one word, hold it until taken, then queue its report
   task automatic send_word(input logic gap, input logic [7:0] b, input logic typed,
                            input rsp_type want);
      rsp_type pred;
      if (send_idle_on && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= gap;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      pred = predict_byte_report(gap, b);
      pending_frame_reports.push_back(typed ? want : pred);
      sent_words++;
   endtask

   // Drain the unit, then write all four registers
   task automatic apply_unit_setup(input logic role, input logic [7:0] own,
                                   input logic bcast, input logic exc);
      req_tvalid <= 1'b0;
      while (pending_frame_reports.size() != 0) @(posedge clock);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_ROLE;
      csr_wdata <= {7'd0, role};
      @(posedge clock);
      csr_index <= CSR_OWN_ADDR;
      csr_wdata <= own;
      @(posedge clock);
      csr_index <= CSR_BROADCAST;
      csr_wdata <= {7'd0, bcast};
      @(posedge clock);
      csr_index <= CSR_EXC_STAT;
      csr_wdata <= {7'd0, exc};
      @(posedge clock);
      csr_we <= 1'b0;
      cfg_role  = role;
      cfg_own   = own;
      cfg_bcast = bcast;
      cfg_exc   = exc;
   endtask

   task automatic add_random(ref logic [7:0] body [$], input int n);
      repeat (n) body.push_back(8'($urandom));
   endtask

   // Build one frame for the current role, mostly well formed, and send it
   task automatic send_frame(input bit allow_idle);
      logic [7:0]  body [$];
      logic [7:0]  a;
      logic [7:0]  fc;
      logic [15:0] crc;
      int          kind;
      int          n;
      int          k;
      bit          broken;
      broken = 1'b0;
      send_idle_on = allow_idle && $urandom_range(0, 2) != 0;
      n = ($urandom_range(0, 24) == 0) ? $urandom_range(200, 255) : $urandom_range(0, 12);

      // resync after noise, and now and then for no reason
      if (dirty || $urandom_range(0, 9) == 0)
         send_word(1'b1, 8'($urandom), 1'b0, '0);

      if (cfg_role == ROLE_MASTER) begin
         body.push_back(8'($urandom));
         kind = $urandom_range(0, 9);
         if (kind < 2) begin
            body.push_back(FC_EXC_MASK | 8'($urandom_range(0, 127)));
            body.push_back(8'($urandom));
         end else if (kind < 6) begin
            body.push_back(8'($urandom_range(FC_READ_COILS, FC_READ_INREG)));
            body.push_back(8'(n));
            if (n > MAX_DATA_BYTES) broken = 1'b1;
            else add_random(body, n);
         end else if (kind < 9) begin
            case ($urandom_range(0, 3))
               0: fc = FC_WRITE_COIL;
               1: fc = FC_WRITE_REG;
               2: fc = FC_WRITE_MCOIL;
               default: fc = FC_WRITE_MREG;
            endcase
            body.push_back(fc);
            add_random(body, 4);
         end else begin
            body.push_back(8'($urandom_range(0, 127)));
            add_random(body, 3);
            broken = 1'b1;
         end
      end else begin
         case ($urandom_range(0, 7))
            0: a = 8'($urandom);
            1: a = 8'h00;
            default: a = cfg_own;
         endcase
         if (!(a == cfg_own || (cfg_bcast && a == 8'h00))) broken = 1'b1;
         body.push_back(a);
         kind = $urandom_range(0, 11);
         if (kind < 4) begin
            body.push_back(8'($urandom_range(FC_READ_COILS, FC_WRITE_REG)));
            add_random(body, 4);
         end else if (kind == 4) begin
            body.push_back(FC_ENCAP);
            add_random(body, 3);
         end else if (kind == 5) begin
            body.push_back(FC_EXC_STATUS);
            if (!cfg_exc) broken = 1'b1;
         end else if (kind < 10) begin
            body.push_back(kind < 8 ? (kind[0] ? FC_WRITE_MCOIL : FC_WRITE_MREG) : FC_RW_MREG);
            add_random(body, kind < 8 ? 4 : 8);
            body.push_back(8'(n));
            if (n > MAX_DATA_BYTES) broken = 1'b1;
            else add_random(body, n);
         end else begin
            body.push_back(8'($urandom));
            add_random(body, 3);
            broken = 1'b1;
         end
      end

      // append CRC, low byte first
      crc = CRC_PRESET;
      foreach (body[i]) crc = crc_fold(crc, body[i]);
      body.push_back(crc[7:0]);
      body.push_back(crc[15:8]);

      // corrupt one bit or cut the tail
      if ($urandom_range(0, 7) == 0) begin
         k = $urandom_range(0, body.size() - 1);
         body[k] = body[k] ^ (8'h01 << $urandom_range(0, 7));
         broken = 1'b1;
      end
      if ($urandom_range(0, 11) == 0) begin
         k = $urandom_range(1, body.size() - 1);
         while (body.size() > k) void'(body.pop_back());
         broken = 1'b1;
      end

      foreach (body[i]) send_word(1'b0, body[i], 1'b0, '0);

      // line noise between frames
      if ($urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(1, 4))
            send_word($urandom_range(0, 3) == 0, 8'($urandom), 1'b0, '0);
         broken = 1'b1;
      end
      dirty = broken;
   endtask

   // Result side ready: random stalls and one long hold-off
   initial begin : rsp_ready_gen
      int span;
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            span = HOLD_CYCLES;
         end else if (rx_stall_on && $urandom_range(0, 5) == 0) begin
            span = $urandom_range(1, 7);
         end else begin
            span = 0;
         end
         if (span != 0) begin
            rsp_tready <= 1'b0;
            repeat (span) @(posedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
         fail_count++;
      end
   endtask

   // Compare each result word with the oldest queued report
   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tdata[23:16], rsp_tdata[15:8], rsp_tdata[7:0],
                rsp_tlast, rsp_tuser[3], rsp_tuser[2:0]};
         if (pending_frame_reports.size() == 0) begin
            $display("%0t: unexpected result word: expected none, got %h", $time, got);
            fail_count++;
         end else begin
            want = pending_frame_reports.pop_front();
            check_field("status", {5'd0, want.status}, {5'd0, got.status});
            check_field("data_byte", want.data_byte, got.data_byte);
            check_field("byte_index", want.byte_index, got.byte_index);
            check_field("is_payload", {7'd0, want.is_payload}, {7'd0, got.is_payload});
            check_field("frame_end", {7'd0, want.frame_end}, {7'd0, got.frame_end});
            check_field("payload_length", want.payload_length, got.payload_length);
         end
      end
   end

   // Abort when no word moves on either side for too long
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   initial begin : stimulus
      int  target;
      bit  tail;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed words at reset settings
      send_idle_on = 1'b1;
      rx_stall_on  = 1'b1;
      for (int i = 0; i < N_PROBE; i++)
         send_word(probe_tbl[i].gap, probe_tbl[i].rx, probe_tbl[i].typed, probe_tbl[i].want);

      // random frames under several settings; the last phase runs without idling
      for (int ph = 1; ph <= N_PHASE; ph++) begin
         tail = (ph == N_PHASE);
         case (ph)
            1: apply_unit_setup(ROLE_MASTER, 8'd0, 1'b0, 1'b0);
            2: apply_unit_setup(ROLE_SLAVE, 8'd247, 1'b1, 1'b1);
            3: apply_unit_setup(ROLE_SLAVE, 8'd0, 1'b0, 1'b1);
            4: apply_unit_setup(ROLE_MASTER, 8'd255, 1'b1, 1'b0);
            5: apply_unit_setup(ROLE_SLAVE, 8'd255, 1'b0, 1'b0);
            default: apply_unit_setup(1'($urandom), 8'($urandom_range(0, 247)),
                                      1'($urandom), 1'($urandom));
         endcase
         dirty = 1'b1;
         rx_stall_on = !tail && $urandom_range(0, 3) != 0;
         if (ph == 2) hold_off_req = 1'b1;
         target = sent_words + PHASE_WORDS;
         while (sent_words < target) send_frame(!tail);
      end

      req_tvalid <= 1'b0;
      while (pending_frame_reports.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (fail_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
